// ===== hw/rtl/mmbd_pkg.sv =====
// Shared types and constants of the min/max bucket decimator.
// Used by every module of the block; has no dependencies of its own.
package mmbd_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned POS_W     = 20;
  localparam int unsigned RATE_W    = 19;
  localparam int unsigned RATIO_W   = 17;
  localparam int unsigned CFG_W     = 20;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Display intervals. The count is a power of two so that the interval
  // boundaries come from a shift.
  localparam int unsigned BUCKETS   = 64;
  localparam int unsigned BKT_SHIFT = $clog2(BUCKETS);
  localparam int unsigned BKT_W     = 6;
  localparam int unsigned CB_W      = $clog2(BUCKETS + 1);

  // Boundary and accumulator widths.
  localparam int unsigned BND_W = POS_W + 1;
  localparam int unsigned ACC_W = POS_W + CB_W;

  // Offset arithmetic: offset_ms_x16 * rate / 16000, done as a shift by 7
  // followed by a reciprocal multiplication for the divide by 125. The
  // constant is ceil(2^35 / 125); it overshoots by 7 / 2^35 per unit, which
  // keeps the floor exact for every 32-bit quotient.
  localparam int unsigned PROD_W    = POS_W + RATE_W;
  localparam int unsigned DIV_PRE   = 7;
  localparam int unsigned QUO_W     = PROD_W - DIV_PRE;
  localparam int unsigned DIV_M_W   = 29;
  localparam logic [DIV_M_W-1:0] DIV_MAGIC = 29'h10624DD3;
  localparam int unsigned DIV_POST  = 35;
  localparam int unsigned RECIP_W   = QUO_W + DIV_M_W;
  localparam int unsigned LENP_W    = POS_W + RATIO_W;
  localparam int unsigned Q16       = 16;

  // Sample queue between the front and the back.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT = 2'd0,
    REG_SOURCE_RATE  = 2'd1,
    REG_OFFSET_MS    = 2'd2,
    REG_PLAY_RATIO   = 2'd3
  } cfg_reg_e;

  typedef enum logic [5:0] {
    ST_RUN   = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_OFF   = 6'b001000,
    ST_LEN   = 6'b010000,
    ST_CLAMP = 6'b100000
  } front_state_e;

  typedef struct packed {
    logic [POS_W-1:0]   sample_count;
    logic [RATE_W-1:0]  source_rate;
    logic [POS_W-1:0]   offset_ms_x16;
    logic [RATIO_W-1:0] play_ratio_q16;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]           pos;
  } entry_t;

  typedef struct packed {
    logic             load;
    logic [POS_W-1:0] off;
    logic [POS_W-1:0] len;
  } span_t;

endpackage

// ===== hw/rtl/min_max_bucket_decimator.sv =====
// Min/max peak decimator: top level with the configuration registers.
// Depends on mmbd_pkg, mmbd_front, mmbd_fifo and mmbd_back.
//
// The block reduces one audio clip, streamed sample by sample in clip order,
// to 64 display intervals and reports the smallest and largest sample of each
// one as soon as its last sample has arrived. The first sample request of a
// clip latches the start offset and the play length from the configuration
// registers; after it is taken the input is stalled while a multiplier and a
// reciprocal multiplication for the divide by 125 work out the offset and a
// second multiplier the play length. After that the back end holds each
// sample at the head of the queue while it closes intervals, one result for
// each, and takes it off once it closes no further interval; the four-entry
// queue between the front and the back lets the input
// keep streaming while the back end works through such a burst, and the output
// register lets a new sample be taken while a result waits. A clip with zero
// samples or a zero rate gives no results. Samples beyond the last interval
// are accepted and ignored. Only reset starts a new clip, and the registers
// should be written before its first sample.
module min_max_bucket_decimator import mmbd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [BKT_W-1:0]           bucket_number_o,
  output logic signed [SAMPLE_W-1:0] min_value_o,
  output logic signed [SAMPLE_W-1:0] max_value_o,
  output logic                       last_bucket_o
);

  cfg_t   cfg_q;
  logic   fifo_full;
  logic   fifo_push;
  entry_t fifo_push_data;
  logic   fifo_pop;
  logic   fifo_valid;
  entry_t fifo_head;
  span_t  span;

  // Configuration registers, written by index with no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_count   <= '0;
      cfg_q.source_rate    <= RATE_W'(48000);
      cfg_q.offset_ms_x16  <= '0;
      cfg_q.play_ratio_q16 <= RATIO_W'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SAMPLE_COUNT: cfg_q.sample_count   <= cfg_wdata_i[POS_W-1:0];
        REG_SOURCE_RATE:  cfg_q.source_rate    <= cfg_wdata_i[RATE_W-1:0];
        REG_OFFSET_MS:    cfg_q.offset_ms_x16  <= cfg_wdata_i[POS_W-1:0];
        REG_PLAY_RATIO:   cfg_q.play_ratio_q16 <= cfg_wdata_i[RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front counts positions and works out the span on the first sample.
  mmbd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_value_i (sample_value_i),
    .fifo_full_i    (fifo_full),
    .push_o         (fifo_push),
    .push_data_o    (fifo_push_data),
    .span_o         (span)
  );

  // Queued samples carry their clip position so the back needs no counter.
  mmbd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (fifo_push_data),
    .pop_i       (fifo_pop),
    .full_o      (fifo_full),
    .valid_o     (fifo_valid),
    .head_o      (fifo_head)
  );

  // The back walks interval boundaries with an accumulator, so no multiply
  // sits in its per-cycle path.
  mmbd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .span_i          (span),
    .head_valid_i    (fifo_valid),
    .head_i          (fifo_head),
    .pop_o           (fifo_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .bucket_number_o (bucket_number_o),
    .min_value_o     (min_value_o),
    .max_value_o     (max_value_o),
    .last_bucket_o   (last_bucket_o)
  );

endmodule

// ===== hw/rtl/mmbd_fifo.sv =====
// Small request queue between the front and the back of the decimator.
// Depends on mmbd_pkg for the entry type and depth.
module mmbd_fifo import mmbd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   valid_o,
  output entry_t head_o
);

  entry_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/mmbd_front.sv =====
// Front of the decimator: takes sample requests, counts clip positions and
// works out the start offset and play length on the first sample.
// Depends on mmbd_pkg.
module mmbd_front import mmbd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_value_i,
  input  logic                       fifo_full_i,
  output logic                       push_o,
  output entry_t                     push_data_o,
  output span_t                      span_o
);

  front_state_e               state_q, state_d;
  logic [POS_W-1:0]           pos_q;
  logic signed [SAMPLE_W-1:0] hold_q;
  logic                       zero_q;
  logic [QUO_W-1:0]           quo_q;
  logic [POS_W-1:0]           off_q;
  logic [POS_W-1:0]           rest_q;
  logic [LENP_W-1:0]          lenp_q;

  logic                       accept;
  logic [PROD_W-1:0]          prod;
  logic [RECIP_W-1:0]         recip;
  logic [POS_W-1:0]           count_m1;
  logic [POS_W-1:0]           off_c;
  logic [BND_W-1:0]           len_raw;
  logic [POS_W-1:0]           len_c;

  assign in_stall_o = (state_q != ST_RUN) || fifo_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign prod     = PROD_W'(cfg_i.offset_ms_x16) * PROD_W'(cfg_i.source_rate);
  assign recip    = RECIP_W'(quo_q) * RECIP_W'(DIV_MAGIC);
  assign count_m1 = cfg_i.sample_count - 1'b1;

  always_comb begin
    if (zero_q) begin
      off_c = '0;
    end else if (quo_q > QUO_W'(count_m1)) begin
      off_c = count_m1;
    end else begin
      off_c = quo_q[POS_W-1:0];
    end
  end

  assign len_raw = lenp_q[LENP_W-1:Q16];

  always_comb begin
    if (zero_q) begin
      len_c = '0;
    end else if (len_raw == '0) begin
      len_c = POS_W'(1);
    end else if (len_raw > BND_W'(rest_q)) begin
      len_c = rest_q;
    end else begin
      len_c = len_raw[POS_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (accept && pos_q == '0) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:   state_d = ST_DIV;
      ST_DIV:   state_d = ST_OFF;
      ST_OFF:   state_d = ST_LEN;
      ST_LEN:   state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_RUN;
      default:  state_d = ST_RUN;
    endcase
  end

  // The first sample is held back until the span is known; later samples go
  // straight into the queue. Samples past the saturated position are dropped.
  assign push_o = (state_q == ST_CLAMP) ||
                  (accept && pos_q != '0 && pos_q != POS_MAX);

  always_comb begin
    if (state_q == ST_CLAMP) begin
      push_data_o.sample = hold_q;
      push_data_o.pos    = '0;
    end else begin
      push_data_o.sample = sample_value_i;
      push_data_o.pos    = pos_q;
    end
  end

  assign span_o.load = (state_q == ST_CLAMP);
  assign span_o.off  = off_q;
  assign span_o.len  = len_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept && pos_q != POS_MAX) begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pos_q == '0) begin
      hold_q <= sample_value_i;
    end
    if (state_q == ST_MUL) begin
      zero_q <= (cfg_i.sample_count == '0) || (cfg_i.source_rate == '0);
      quo_q  <= prod[PROD_W-1:DIV_PRE];
    end
    if (state_q == ST_DIV) begin
      quo_q <= QUO_W'(recip[RECIP_W-1:DIV_POST]);
    end
    if (state_q == ST_OFF) begin
      off_q  <= off_c;
      rest_q <= cfg_i.sample_count - off_c;
    end
    if (state_q == ST_LEN) begin
      lenp_q <= LENP_W'(rest_q) * LENP_W'(cfg_i.play_ratio_q16);
    end
  end

endmodule

// ===== hw/rtl/mmbd_back.sv =====
// Back of the decimator: walks the interval boundaries for each queued sample,
// keeps the running extremes and emits one interval result per cycle unless the output stalls.
// Depends on mmbd_pkg.
module mmbd_back import mmbd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  span_t                      span_i,
  input  logic                       head_valid_i,
  input  entry_t                     head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [BKT_W-1:0]           bucket_number_o,
  output logic signed [SAMPLE_W-1:0] min_value_o,
  output logic signed [SAMPLE_W-1:0] max_value_o,
  output logic                       last_bucket_o
);

  logic [POS_W-1:0]           off_q;
  logic [POS_W-1:0]           len_q;
  logic [CB_W-1:0]            cb_q;
  logic [BND_W-1:0]           from_q;
  logic [BND_W-1:0]           to_q;
  logic [ACC_W-1:0]           acc_q;
  logic signed [SAMPLE_W-1:0] min_q, max_q;
  logic                       out_valid_q;
  logic [BKT_W-1:0]           out_bkt_q;
  logic signed [SAMPLE_W-1:0] out_min_q, out_max_q;
  logic                       out_last_q;

  logic                       done;
  logic [BND_W-1:0]           p_ext;
  logic [BND_W-1:0]           to_eff;
  logic                       pre_start;
  logic                       at_from;
  logic                       ends;
  logic                       out_free;
  logic                       emit;
  logic                       update;
  logic signed [SAMPLE_W-1:0] min_n, max_n;

  // A degenerate interval (raw end equal to its start) still covers one sample.
  assign done      = (cb_q == CB_W'(BUCKETS)) || (len_q == '0);
  assign p_ext     = BND_W'(head_i.pos);
  assign to_eff    = (to_q == from_q) ? from_q + 1'b1 : to_q;
  assign pre_start = p_ext < from_q;
  assign at_from   = p_ext == from_q;
  assign ends      = (p_ext + 1'b1) == to_eff;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    if (at_from) begin
      min_n = head_i.sample;
      max_n = head_i.sample;
    end else begin
      min_n = (head_i.sample < min_q) ? head_i.sample : min_q;
      max_n = (head_i.sample > max_q) ? head_i.sample : max_q;
    end
  end

  // The sample leaves the queue once it closes no further interval; each
  // closed interval is emitted while the sample is held at the head.
  assign pop_o  = head_valid_i && (done || pre_start || !ends);
  assign emit   = head_valid_i && !done && !pre_start && ends && out_free;
  assign update = head_valid_i && !done && !pre_start && (!ends || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_q        <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (span_i.load) begin
        cb_q  <= '0;
        len_q <= span_i.len;
      end else if (emit) begin
        cb_q <= cb_q + 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '0;
    end else if (update) begin
      min_q <= min_n;
      max_q <= max_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (span_i.load) begin
      off_q  <= span_i.off;
      from_q <= BND_W'(span_i.off);
      to_q   <= BND_W'(span_i.off) + BND_W'(span_i.len >> BKT_SHIFT);
      acc_q  <= ACC_W'(span_i.len) << 1;
    end else if (emit) begin
      from_q <= to_q;
      to_q   <= BND_W'(off_q) + BND_W'(acc_q >> BKT_SHIFT);
      acc_q  <= acc_q + ACC_W'(len_q);
    end
    if (emit) begin
      out_bkt_q  <= cb_q[BKT_W-1:0];
      out_min_q  <= min_n;
      out_max_q  <= max_n;
      out_last_q <= (cb_q == CB_W'(BUCKETS - 1));
    end
  end

  assign out_valid_o     = out_valid_q;
  assign bucket_number_o = out_bkt_q;
  assign min_value_o     = out_min_q;
  assign max_value_o     = out_max_q;
  assign last_bucket_o   = out_last_q;

endmodule

// ===== tb/tb_min_max_bucket_decimator.sv =====
// Self-checking testbench of the min/max bucket decimator.
// Depends on mmbd_pkg and min_max_bucket_decimator; keeps its own model of the interval
// bookkeeping and checks every result against it or against a typed-in row, in order.
module tb_min_max_bucket_decimator;
  import mmbd_pkg::*;

  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES = 40000;
  // Cycles to let pass once nothing is pending: covers the offset divide on the
  // first sample and a back end that is still walking a sample with no result.
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES   = 100;
  localparam int unsigned REPORT_LIMIT  = 10;

  // The clip. Reset is applied only once, so the whole run is one clip.
  // At 16 kHz an offset of 4/16 ms is 4 samples; the 192 samples after it are
  // cut into intervals of exactly 3, and a ratio above one is clamped to them.
  localparam logic [CFG_W-1:0] CLIP_SAMPLES = 20'd196;
  localparam logic [CFG_W-1:0] CLIP_RATE    = 20'd16000;
  localparam logic [CFG_W-1:0] CLIP_OFFSET  = 20'd4;
  localparam logic [CFG_W-1:0] CLIP_RATIO   = 20'h1FFFF;

  localparam int unsigned RANDOM_ITEMS = 184;
  localparam int unsigned HOLD_AT      = 40;
  localparam int unsigned REPROG_A     = 80;
  localparam int unsigned REPROG_B     = 150;
  localparam int unsigned QUIET_AT     = 165;

  typedef struct packed {
    logic [BKT_W-1:0]           bucket;
    logic signed [SAMPLE_W-1:0] min_v;
    logic signed [SAMPLE_W-1:0] max_v;
    logic                       last;
  } bucket_res_t;

  // How a directed row is checked: by the model, or by a typed-in result.
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NONE,
    ROW_ONE
  } row_kind_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    row_kind_e                  kind;
    logic [BKT_W-1:0]           bucket;
    logic signed [SAMPLE_W-1:0] min_v;
    logic signed [SAMPLE_W-1:0] max_v;
    logic                       last;
  } stim_row_t;

  localparam int unsigned N_ROWS = 20;
  localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
    // Ahead of the start offset: even the extremes give nothing.
    '{16'sh7FFF, ROW_NONE, 6'd0, 16'sh0000, 16'sh0000, 1'b0},
    '{16'sh8000, ROW_NONE, 6'd0, 16'sh0000, 16'sh0000, 1'b0},
    '{16'sh0000, ROW_NONE, 6'd0, 16'sh0000, 16'sh0000, 1'b0},
    '{16'shFFFF, ROW_NONE, 6'd0, 16'sh0000, 16'sh0000, 1'b0},
    // Interval 0 holds both extremes.
    '{16'sh8000, ROW_NONE, 6'd0, 16'sh0000, 16'sh0000, 1'b0},
    '{16'sh7FFF, ROW_NONE, 6'd0, 16'sh0000, 16'sh0000, 1'b0},
    '{16'shFFFF, ROW_ONE,  6'd0, 16'sh8000, 16'sh7FFF, 1'b0},
    // Interval 1 is flat at minus one.
    '{16'shFFFF, ROW_NONE, 6'd0, 16'sh0000, 16'sh0000, 1'b0},
    '{16'shFFFF, ROW_NONE, 6'd0, 16'sh0000, 16'sh0000, 1'b0},
    '{16'shFFFF, ROW_ONE,  6'd1, 16'shFFFF, 16'shFFFF, 1'b0},
    // Interval 2 toggles every bit.
    '{16'sh5555, ROW_NONE, 6'd0, 16'sh0000, 16'sh0000, 1'b0},
    '{16'shAAAA, ROW_NONE, 6'd0, 16'sh0000, 16'sh0000, 1'b0},
    '{16'shFFFE, ROW_ONE,  6'd2, 16'shAAAA, 16'sh5555, 1'b0},
    // Interval 3 sits at the top; the old minimum must not carry over.
    '{16'sh7FFF, ROW_NONE, 6'd0, 16'sh0000, 16'sh0000, 1'b0},
    '{16'sh7FFF, ROW_NONE, 6'd0, 16'sh0000, 16'sh0000, 1'b0},
    '{16'sh7FFF, ROW_ONE,  6'd3, 16'sh7FFF, 16'sh7FFF, 1'b0},
    '{16'sh0064, ROW_PREDICT, 6'd0, 16'sh0000, 16'sh0000, 1'b0},
    '{16'shFF38, ROW_PREDICT, 6'd0, 16'sh0000, 16'sh0000, 1'b0},
    '{16'sh012C, ROW_PREDICT, 6'd0, 16'sh0000, 16'sh0000, 1'b0},
    '{16'shFE70, ROW_PREDICT, 6'd0, 16'sh0000, 16'sh0000, 1'b0}
  };

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = REG_SAMPLE_COUNT;
  logic [CFG_W-1:0]           cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_stall;
  logic [BKT_W-1:0]           bucket_number;
  logic signed [SAMPLE_W-1:0] min_value;
  logic signed [SAMPLE_W-1:0] max_value;
  logic                       last_bucket;

  // The receiver stall is the OR of random bursts and one long hold-off.
  logic stall_rand = 1'b0;
  logic stall_hold = 1'b0;
  bit   hold_go = 1'b0;
  bit   quiet_tail = 1'b0;
  assign out_stall = stall_rand | stall_hold;

  int unsigned fail_count = 0;

  // Model of the registers and of the clip state.
  logic [POS_W-1:0]           m_count = '0;
  logic [RATE_W-1:0]          m_rate = 19'd48000;
  logic [POS_W-1:0]           m_offset_ms = '0;
  logic [RATIO_W-1:0]         m_ratio = 17'd65536;
  logic [POS_W-1:0]           m_pos = '0;
  logic [POS_W-1:0]           m_start = '0;
  logic [POS_W-1:0]           m_span = '0;
  logic [CB_W-1:0]            m_bucket = '0;
  logic signed [SAMPLE_W-1:0] m_min = '0;
  logic signed [SAMPLE_W-1:0] m_max = '0;

  bucket_res_t pending_buckets [$];

  min_max_bucket_decimator u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_value_i (sample),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .bucket_number_o(bucket_number),
    .min_value_o    (min_value),
    .max_value_o    (max_value),
    .last_bucket_o  (last_bucket)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Test completed with failures");
    $finish;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
  endfunction

  // First sample of interval b, relative to the clip.
  function automatic logic [63:0] interval_start(input int unsigned b);
    return 64'(m_start) + (64'(m_span) * 64'(b)) / 64'(BUCKETS);
  endfunction

  // Offset and play length, taken from the registers on the first sample.
  task automatic latch_span();
    logic [63:0] off;
    logic [63:0] rest;
    logic [63:0] len;
    if (m_count == '0 || m_rate == '0) begin
      m_start = '0;
      m_span  = '0;
    end else begin
      off = (64'(m_offset_ms) * 64'(m_rate)) / 64'd16000;
      if (off > 64'(m_count) - 64'd1) off = 64'(m_count) - 64'd1;
      rest = 64'(m_count) - off;
      len  = (rest * 64'(m_ratio)) >> Q16;
      if (len < 64'd1) len = 64'd1;
      if (len > rest) len = rest;
      m_start = off[POS_W-1:0];
      m_span  = len[POS_W-1:0];
    end
  endtask

  // Folds one accepted sample into the running extremes and queues every
  // interval that it closes; degenerate intervals all close on one sample.
  task automatic fold_sample(input logic signed [SAMPLE_W-1:0] s, output int produced);
    logic [63:0] p;
    logic [63:0] from;
    logic [63:0] upto;
    bucket_res_t r;
    bit          done;
    produced = 0;
    if (m_pos != POS_MAX) begin
      if (m_pos == '0) latch_span();
      p     = 64'(m_pos);
      m_pos = m_pos + 1'b1;
      done  = (m_span == '0);
      while (!done && m_bucket < BUCKETS) begin
        from = interval_start(m_bucket);
        upto = interval_start(m_bucket + 1);
        if (upto <= from) upto = from + 64'd1;
        if (p < from) begin
          done = 1'b1;
        end else begin
          if (p == from) begin
            m_min = s;
            m_max = s;
          end else begin
            if (s < m_min) m_min = s;
            if (s > m_max) m_max = s;
          end
          if (p + 64'd1 != upto) begin
            done = 1'b1;
          end else begin
            r.bucket = m_bucket[BKT_W-1:0];
            r.min_v  = m_min;
            r.max_v  = m_max;
            r.last   = (m_bucket == CB_W'(BUCKETS - 1));
            pending_buckets.insert(pending_buckets.size(), r);
            produced++;
            m_bucket = m_bucket + 1'b1;
          end
        end
      end
    end
  endtask

  // Writes all four registers on consecutive edges; the enable drops after the last.
  task automatic program_regs(input logic [CFG_W-1:0] cnt, input logic [CFG_W-1:0] rate,
                              input logic [CFG_W-1:0] offs, input logic [CFG_W-1:0] ratio);
    logic [CFG_W-1:0] vals [4];
    vals = '{cnt, rate, offs, ratio};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_e'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      case (cfg_reg_e'(i))
        REG_SAMPLE_COUNT: m_count     = vals[i];
        REG_SOURCE_RATE:  m_rate      = vals[i][RATE_W-1:0];
        REG_OFFSET_MS:    m_offset_ms = vals[i];
        REG_PLAY_RATIO:   m_ratio     = vals[i][RATIO_W-1:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // Offers one sample and returns once it has been accepted and folded in.
  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] v, output int produced);
    in_valid <= 1'b1;
    sample   <= v;
    do @(posedge clk); while (in_stall);
    fold_sample(v, produced);
  endtask

  task automatic pause_input(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Random gap after a request, except during the hold-off and the quiet tail.
  task automatic maybe_pause();
    if (!quiet_tail && !stall_hold && $urandom_range(0, 3) == 0)
      pause_input($urandom_range(1, 7));
  endtask

  // Lets every pending result arrive, then lets the back end settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_buckets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Random receiver stalls in bursts, none in the tail.
  initial begin
    int unsigned len;
    @(posedge rst_n);
    forever begin
      if (quiet_tail) begin
        stall_rand <= 1'b0;
        @(posedge clk);
      end else begin
        len = $urandom_range(1, 7);
        stall_rand <= ($urandom_range(0, 2) == 0);
        repeat (len) @(posedge clk);
      end
    end
  end

  // One long hold-off of the receiver so that the queue fills and the input stalls.
  initial begin
    wait (hold_go);
    @(posedge clk);
    stall_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    stall_hold <= 1'b0;
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    bucket_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_buckets.size() == 0) begin
        note_failure($sformatf("unexpected result bucket %0d min %0d max %0d last %0b",
                               bucket_number, min_value, max_value, last_bucket));
      end else begin
        want = pending_buckets.pop_front();
        if (bucket_number !== want.bucket || min_value !== want.min_v ||
            max_value !== want.max_v || last_bucket !== want.last)
          note_failure($sformatf(
              "expected bucket %0d min %0d max %0d last %0b, got %0d %0d %0d %0b",
              want.bucket, want.min_v, want.max_v, want.last,
              bucket_number, min_value, max_value, last_bucket));
      end
    end
  end

  initial begin
    int          produced;
    bucket_res_t typed_res;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_regs(CLIP_SAMPLES, CLIP_RATE, CLIP_OFFSET, CLIP_RATIO);
    @(posedge clk);

    // Directed rows: typed-in rows replace what the model queued for them.
    for (int r = 0; r < N_ROWS; r++) begin
      offer_sample(DIRECTED_ROWS[r].value, produced);
      if (DIRECTED_ROWS[r].kind != ROW_PREDICT) begin
        repeat (produced) void'(pending_buckets.pop_back());
        if (DIRECTED_ROWS[r].kind == ROW_ONE) begin
          typed_res = '{DIRECTED_ROWS[r].bucket, DIRECTED_ROWS[r].min_v,
                        DIRECTED_ROWS[r].max_v, DIRECTED_ROWS[r].last};
          pending_buckets.insert(pending_buckets.size(), typed_res);
        end
      end
      maybe_pause();
    end

    // Random samples for the rest of the clip and a little past its end. The
    // registers are rewritten mid-clip; the latched span must not move.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == HOLD_AT) hold_go = 1'b1;
      if (k == REPROG_A) begin
        drain_results();
        program_regs(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
      end
      if (k == REPROG_B) begin
        drain_results();
        program_regs(20'd0, 20'd384000, 20'd0, 20'd0);
      end
      if (k == QUIET_AT) quiet_tail = 1'b1;
      offer_sample(pick_sample(), produced);
      maybe_pause();
    end
    in_valid <= 1'b0;

    while (pending_buckets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== min_max_bucket_decimator.f =====
hw/rtl/mmbd_pkg.sv
hw/rtl/mmbd_fifo.sv
hw/rtl/mmbd_front.sv
hw/rtl/mmbd_back.sv
hw/rtl/min_max_bucket_decimator.sv
tb/tb_min_max_bucket_decimator.sv
